// File: design/bpps_pkg.sv
package bpps_pkg;

  localparam int ROWS_PER_WORD_DEF  = 32;
  localparam int MAX_VALUE_BITS_DEF = 32;
  localparam int LANE_ROWS          = 8;

  localparam int COUNT_W    = 29;
  localparam int GROUP_W    = 24;
  localparam int GROUPS_W   = 25;
  localparam int CONST_W    = 32;
  localparam int VBITS_W    = 6;
  localparam int MODE_W     = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [COUNT_W-1:0]  COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [GROUPS_W-1:0] GROUP_MAX = 25'h100_0000;

  // predicate codes
  localparam logic [MODE_W-1:0] PRED_LT  = 3'd0;
  localparam logic [MODE_W-1:0] PRED_LE  = 3'd1;
  localparam logic [MODE_W-1:0] PRED_GT  = 3'd2;
  localparam logic [MODE_W-1:0] PRED_GE  = 3'd3;
  localparam logic [MODE_W-1:0] PRED_EQ  = 3'd4;
  localparam logic [MODE_W-1:0] PRED_NE  = 3'd5;
  localparam logic [MODE_W-1:0] PRED_BTW = 3'd6;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PRED_MODE    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_VALUE_BITS   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COMPARE_LOW  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COMPARE_HIGH = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_GROUPS       = 3'd4;

  typedef struct packed {
    logic              upd;   // plane word accepted
    logic              last;  // last plane of the group
    logic              c1;    // plane bit of the low constant
    logic              c2;    // plane bit of the high constant (of the low one in modes below between)
    logic [MODE_W-1:0] mode;
  } bpps_lane_ctrl_t;

endpackage

// File: design/bpps_lane.sv
module bpps_lane #(
  parameter int LW = 8,
  parameter int CW = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  bpps_pkg::bpps_lane_ctrl_t ctrl,
  input  logic [LW-1:0]            word,
  output logic [LW-1:0]            res,
  output logic [CW-1:0]            cnt
);

  logic [LW-1:0] gt_r, lt_r, eql_r, eqh_r;
  logic [LW-1:0] gt_nxt, lt_nxt, eql_nxt, eqh_nxt;
  logic [LW-1:0] c1_v, c2_v;
  logic [LW-1:0] res_nxt, res_r;
  logic [CW-1:0] cnt_nxt, cnt_r;

  assign c1_v = {LW{ctrl.c1}};
  assign c2_v = {LW{ctrl.c2}};

  always_comb begin
    gt_nxt  = gt_r | (eql_r & ~c1_v & word);
    lt_nxt  = lt_r | (eqh_r & c2_v & ~word);
    eql_nxt = eql_r & ~(word ^ c1_v);
    eqh_nxt = eqh_r & ~(word ^ c2_v);
  end

  always_comb begin
    case (ctrl.mode)
      bpps_pkg::PRED_LT:  res_nxt = lt_nxt;
      bpps_pkg::PRED_LE:  res_nxt = lt_nxt | eqh_nxt;
      bpps_pkg::PRED_GT:  res_nxt = gt_nxt;
      bpps_pkg::PRED_GE:  res_nxt = gt_nxt | eql_nxt;
      bpps_pkg::PRED_EQ:  res_nxt = eql_nxt;
      bpps_pkg::PRED_NE:  res_nxt = ~eql_nxt;
      default:            res_nxt = gt_nxt & lt_nxt;
    endcase
  end

  always_comb begin
    cnt_nxt = '0;
    for (int i = 0; i < LW; i++) begin
      cnt_nxt = cnt_nxt + CW'(res_nxt[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gt_r  <= '0;
      lt_r  <= '0;
      eql_r <= '1;
      eqh_r <= '1;
    end else if (ctrl.upd) begin
      if (ctrl.last) begin
        // start the next group afresh
        gt_r  <= '0;
        lt_r  <= '0;
        eql_r <= '1;
        eqh_r <= '1;
      end else begin
        gt_r  <= gt_nxt;
        lt_r  <= lt_nxt;
        eql_r <= eql_nxt;
        eqh_r <= eqh_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.upd && ctrl.last) begin
      res_r <= res_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign res = res_r;
  assign cnt = cnt_r;

endmodule

// File: design/bpps_merge.sv
module bpps_merge #(
  parameter int ROWS  = 32,
  parameter int LANES = 4,
  parameter int CW    = 4,
  parameter int OUT_W = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        s1_valid,
  input  logic                        s1_done,
  input  logic [ROWS-1:0]             s1_mask,
  input  logic [LANES-1:0][CW-1:0]    s1_cnt,
  output logic                        s1_take,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [OUT_W-1:0]            out_tdata,
  output logic                        out_tlast
);

  localparam int SW = $clog2(ROWS + 1);
  localparam int TW = bpps_pkg::COUNT_W + 1;

  logic                         out_valid_r, out_valid_nxt;
  logic [ROWS-1:0]              out_mask_r;
  logic [bpps_pkg::COUNT_W-1:0] out_total_r;
  logic                         out_last_r;
  logic [bpps_pkg::COUNT_W-1:0] running_r, running_nxt;
  logic [SW-1:0]                sum;
  logic [TW-1:0]                total_wide;
  logic [bpps_pkg::COUNT_W-1:0] total;

  // add up what the lanes counted
  always_comb begin
    sum = '0;
    for (int l = 0; l < LANES; l++) begin
      sum = sum + SW'(s1_cnt[l]);
    end
  end

  always_comb begin
    total_wide = TW'(running_r) + TW'(sum);
    if (total_wide > TW'(bpps_pkg::COUNT_MAX)) begin
      total = bpps_pkg::COUNT_MAX;
    end else begin
      total = total_wide[bpps_pkg::COUNT_W-1:0];
    end
  end

  assign s1_take       = s1_valid && (!out_valid_r || out_tready);
  assign out_valid_nxt = s1_take || (out_valid_r && !out_tready);
  assign running_nxt   = s1_done ? '0 : total;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      running_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (s1_take) begin
        running_r <= running_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      out_mask_r  <= s1_mask;
      out_total_r <= total;
      out_last_r  <= s1_done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_total_r, out_mask_r});
  assign out_tlast  = out_last_r;

endmodule

// File: design/bit_plane_predicate_scan.sv
// One bit-plane word is taken per cycle while the input is open, with no gap between groups.
// A group's result is registered in the lane mask registers once its last plane is
// accepted, and then in the output register of the count merge.
// Results drain at one per cycle while out_tready is high; the output register
// and the stage before it hold one result each; the input closes while both wait.
// rst_n (synchronous, active low) restores register defaults and clears masks,
// plane and group counters and the running match count.
module bit_plane_predicate_scan #(
  parameter int ROWS_PER_WORD  = bpps_pkg::ROWS_PER_WORD_DEF,
  parameter int MAX_VALUE_BITS = bpps_pkg::MAX_VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((ROWS_PER_WORD+7)/8)*8-1:0]  in_tdata,   // plane_word
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // row_mask, match_total
  output logic [((ROWS_PER_WORD+bpps_pkg::COUNT_W+7)/8)*8-1:0] out_tdata,
  output logic                                out_tlast,  // scan_done
  input  logic                                cfg_we,
  input  logic [bpps_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [bpps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int ROWS  = ROWS_PER_WORD;
  localparam int LR    = bpps_pkg::LANE_ROWS;
  localparam int LANES = (ROWS + LR - 1) / LR;
  localparam int CW    = $clog2(LR + 1);
  localparam int OUT_W = ((ROWS + bpps_pkg::COUNT_W + 7) / 8) * 8;
  localparam int VBW   = $clog2(MAX_VALUE_BITS + 1);
  localparam int PIW   = (MAX_VALUE_BITS > 1) ? $clog2(MAX_VALUE_BITS) : 1;
  localparam int CMPW  = (VBW > bpps_pkg::VBITS_W) ? VBW : bpps_pkg::VBITS_W;
  localparam int SHW   = 2 * bpps_pkg::CONST_W;

  // configuration registers
  logic [bpps_pkg::MODE_W-1:0]   pred_mode_r;
  logic [bpps_pkg::VBITS_W-1:0]  value_bits_r;
  logic [bpps_pkg::CONST_W-1:0]  compare_low_r;
  logic [bpps_pkg::CONST_W-1:0]  compare_high_r;
  logic [bpps_pkg::GROUPS_W-1:0] groups_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pred_mode_r    <= bpps_pkg::PRED_BTW;
      value_bits_r   <= bpps_pkg::VBITS_W'(32);
      compare_low_r  <= '0;
      compare_high_r <= '0;
      groups_r       <= bpps_pkg::GROUPS_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        bpps_pkg::REG_PRED_MODE:    pred_mode_r    <= cfg_wdata[bpps_pkg::MODE_W-1:0];
        bpps_pkg::REG_VALUE_BITS:   value_bits_r   <= cfg_wdata[bpps_pkg::VBITS_W-1:0];
        bpps_pkg::REG_COMPARE_LOW:  compare_low_r  <= cfg_wdata[bpps_pkg::CONST_W-1:0];
        bpps_pkg::REG_COMPARE_HIGH: compare_high_r <= cfg_wdata[bpps_pkg::CONST_W-1:0];
        bpps_pkg::REG_GROUPS:       groups_r       <= cfg_wdata[bpps_pkg::GROUPS_W-1:0];
        default: ;
      endcase
    end
  end

  // plane and group sequencing
  logic [PIW-1:0]               plane_r, plane_nxt, plane_eff;
  logic [bpps_pkg::GROUP_W-1:0] group_r, group_nxt;
  logic [CMPW-1:0]              vb_wide;
  logic [VBW-1:0]               vb, vb_m1;
  logic [PIW-1:0]               bitpos;
  logic                         last_plane;
  logic [bpps_pkg::GROUPS_W-1:0] groups_eff;
  logic                         group_done;
  logic [SHW-1:0]               lo_sh, hi_sh;
  logic [bpps_pkg::CONST_W-1:0] hi_const;
  logic                         in_accept;
  logic                         s1_valid_r, s1_valid_nxt, s1_done_r;
  logic                         s1_take;
  bpps_pkg::bpps_lane_ctrl_t    ctrl;

  always_comb begin
    if (value_bits_r == '0) begin
      vb_wide = CMPW'(1);
    end else if (CMPW'(value_bits_r) > CMPW'(MAX_VALUE_BITS)) begin
      vb_wide = CMPW'(MAX_VALUE_BITS);
    end else begin
      vb_wide = CMPW'(value_bits_r);
    end
    vb    = vb_wide[VBW-1:0];
    vb_m1 = vb - VBW'(1);
    // a lowered plane count ends the group on this plane
    if (VBW'(plane_r) >= vb) begin
      plane_eff = vb_m1[PIW-1:0];
    end else begin
      plane_eff = plane_r;
    end
    last_plane = (VBW'(plane_eff) == vb_m1);
    bitpos     = vb_m1[PIW-1:0] - plane_eff;
  end

  assign hi_const = (pred_mode_r < bpps_pkg::PRED_BTW) ? compare_low_r : compare_high_r;
  assign lo_sh    = SHW'(compare_low_r) >> bitpos;
  assign hi_sh    = SHW'(hi_const) >> bitpos;

  always_comb begin
    if (groups_r == '0) begin
      groups_eff = bpps_pkg::GROUPS_W'(1);
    end else if (groups_r > bpps_pkg::GROUP_MAX) begin
      groups_eff = bpps_pkg::GROUP_MAX;
    end else begin
      groups_eff = groups_r;
    end
    group_done = (bpps_pkg::GROUPS_W'(group_r) + bpps_pkg::GROUPS_W'(1)) >= groups_eff;
  end

  assign in_tready    = !s1_valid_r || s1_take;
  assign in_accept    = in_tvalid && in_tready;
  assign plane_nxt    = last_plane ? '0 : plane_eff + PIW'(1);
  assign group_nxt    = group_done ? '0 : group_r + bpps_pkg::GROUP_W'(1);
  assign s1_valid_nxt = (s1_valid_r && !s1_take) || (in_accept && last_plane);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r    <= '0;
      group_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (in_accept) begin
        plane_r <= plane_nxt;
        if (last_plane) begin
          group_r <= group_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && last_plane) begin
      s1_done_r <= group_done;
    end
  end

  assign ctrl.upd  = in_accept;
  assign ctrl.last = last_plane;
  assign ctrl.c1   = lo_sh[0];
  assign ctrl.c2   = hi_sh[0];
  assign ctrl.mode = pred_mode_r;

  // lanes of rows, the last one may be narrower
  logic [ROWS-1:0]              lane_mask;
  logic [LANES-1:0][CW-1:0]     lane_cnt;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    localparam int LW = (l == LANES - 1) ? ROWS - (LANES - 1) * LR : LR;
    logic [$clog2(LW+1)-1:0] cnt_l;

    bpps_lane #(
      .LW (LW),
      .CW ($clog2(LW + 1))
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .word  (in_tdata[l*LR +: LW]),
      .res   (lane_mask[l*LR +: LW]),
      .cnt   (cnt_l)
    );

    assign lane_cnt[l] = CW'(cnt_l);
  end

  bpps_merge #(
    .ROWS  (ROWS),
    .LANES (LANES),
    .CW    (CW),
    .OUT_W (OUT_W)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid_r),
    .s1_done    (s1_done_r),
    .s1_mask    (lane_mask),
    .s1_cnt     (lane_cnt),
    .s1_take    (s1_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: sim/tb_bit_plane_predicate_scan.sv
module tb_bit_plane_predicate_scan;

  localparam int ROWS = 32;
  localparam int MAX_PLANES = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 6;

  typedef struct packed {
    logic [ROWS-1:0]              row_mask;
    logic [bpps_pkg::COUNT_W-1:0] match_total;
    logic                         scan_done;
  } group_result_t;

  typedef logic [31:0] row_set_t [ROWS];

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [31:0]                     in_tdata;   // plane_word
  logic                            out_tvalid;
  logic                            out_tready;
  logic [63:0]                     out_tdata;  // row_mask, match_total
  logic                            out_tlast;  // scan_done
  logic                            cfg_we;
  logic [bpps_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [bpps_pkg::CFG_DATA_W-1:0] cfg_wdata;

  bit_plane_predicate_scan uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // register copies
  logic [bpps_pkg::MODE_W-1:0]   mode_q;
  logic [bpps_pkg::VBITS_W-1:0]  vbits_q;
  logic [31:0]                   low_q;
  logic [31:0]                   high_q;
  logic [bpps_pkg::GROUPS_W-1:0] groups_q;

  // running row masks of the open group
  logic [ROWS-1:0] gt_rows;
  logic [ROWS-1:0] lt_rows;
  logic [ROWS-1:0] eq_low_rows;
  logic [ROWS-1:0] eq_high_rows;
  int unsigned     plane_no;
  int unsigned     group_no;
  int unsigned     match_sum;

  group_result_t expected_groups[$];
  group_result_t got_group;

  int errors;
  int sender_idle_pct;
  int receiver_stall_pct;
  int hold_off_cycles;
  int cycle_count;
  int unsigned planes_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic int unsigned planes_per_group();
    if (vbits_q == 0) return 1;
    if (vbits_q > MAX_PLANES) return MAX_PLANES;
    return 32'(vbits_q);
  endfunction

  function automatic void clear_group_masks();
    gt_rows = '0;
    lt_rows = '0;
    eq_low_rows = '1;
    eq_high_rows = '1;
    plane_no = 0;
  endfunction

  task automatic predict_plane(input logic [31:0] w);
    int unsigned   vb;
    int unsigned   bitpos;
    int unsigned   groups;
    logic [31:0]   upper;
    logic [31:0]   c1;
    logic [31:0]   c2;
    logic [31:0]   row_hits;
    group_result_t res;
    vb = planes_per_group();
    // a lowered plane count ends the open group on this plane
    if (plane_no >= vb) plane_no = vb - 1;
    upper = (mode_q < bpps_pkg::PRED_BTW) ? low_q : high_q;
    bitpos = vb - 1 - plane_no;
    c1 = {32{low_q[bitpos]}};
    c2 = {32{upper[bitpos]}};
    gt_rows = gt_rows | (eq_low_rows & ~c1 & w);
    lt_rows = lt_rows | (eq_high_rows & c2 & ~w);
    eq_low_rows = eq_low_rows & ~(w ^ c1);
    eq_high_rows = eq_high_rows & ~(w ^ c2);
    if (plane_no + 1 < vb) begin
      plane_no++;
      return;
    end
    case (mode_q)
      bpps_pkg::PRED_LT: row_hits = lt_rows;
      bpps_pkg::PRED_LE: row_hits = lt_rows | eq_high_rows;
      bpps_pkg::PRED_GT: row_hits = gt_rows;
      bpps_pkg::PRED_GE: row_hits = gt_rows | eq_low_rows;
      bpps_pkg::PRED_EQ: row_hits = eq_low_rows;
      bpps_pkg::PRED_NE: row_hits = ~eq_low_rows;
      default:           row_hits = gt_rows & lt_rows;
    endcase
    match_sum = match_sum + $countones(row_hits);
    if (match_sum > 32'(bpps_pkg::COUNT_MAX)) match_sum = 32'(bpps_pkg::COUNT_MAX);
    groups = (groups_q == 0) ? 1 : 32'(groups_q);
    if (groups > 32'(bpps_pkg::GROUP_MAX)) groups = 32'(bpps_pkg::GROUP_MAX);
    res.row_mask = row_hits;
    res.match_total = match_sum[bpps_pkg::COUNT_W-1:0];
    res.scan_done = (group_no + 1 >= groups);
    expected_groups.push_back(res);
    clear_group_masks();
    if (res.scan_done) begin
      group_no = 0;
      match_sum = 0;
    end else begin
      group_no = (group_no + 1) & 32'h00ff_ffff;
    end
  endtask

  // hold the write enable high; the caller lowers it after the last write
  task automatic write_reg(input logic [bpps_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [bpps_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      bpps_pkg::REG_PRED_MODE:    mode_q = data[bpps_pkg::MODE_W-1:0];
      bpps_pkg::REG_VALUE_BITS:   vbits_q = data[bpps_pkg::VBITS_W-1:0];
      bpps_pkg::REG_COMPARE_LOW:  low_q = data;
      bpps_pkg::REG_COMPARE_HIGH: high_q = data;
      bpps_pkg::REG_GROUPS:       groups_q = data[bpps_pkg::GROUPS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [bpps_pkg::MODE_W-1:0] mode, input int unsigned vb,
                            input logic [31:0] lo, input logic [31:0] hi,
                            input logic [bpps_pkg::GROUPS_W-1:0] groups);
    write_reg(bpps_pkg::REG_PRED_MODE, bpps_pkg::CFG_DATA_W'(mode));
    write_reg(bpps_pkg::REG_VALUE_BITS, bpps_pkg::CFG_DATA_W'(vb));
    write_reg(bpps_pkg::REG_COMPARE_LOW, lo);
    write_reg(bpps_pkg::REG_COMPARE_HIGH, hi);
    write_reg(bpps_pkg::REG_GROUPS, bpps_pkg::CFG_DATA_W'(groups));
    cfg_we <= 1'b0;
  endtask

  task automatic send_plane(input logic [31:0] w);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w;
    do @(posedge clk); while (!in_tready);
    predict_plane(w);
    planes_sent++;
  endtask

  // transpose row values into planes, most significant plane first
  task automatic send_rows(input row_set_t rows, input int unsigned nplanes);
    int unsigned vb;
    logic [31:0] w;
    vb = planes_per_group();
    for (int p = 0; p < nplanes; p++) begin
      for (int k = 0; k < ROWS; k++) w[ROWS-1-k] = rows[k][vb-1-p];
      send_plane(w);
    end
  endtask

  // drop valid, wait for every outstanding word, then let the pipeline empty
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_groups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_row(input int unsigned vb);
    logic [63:0] span;
    logic [31:0] v;
    span = (64'd1 << vb) - 1;
    case ($urandom_range(7))
      0:       v = low_q;
      1:       v = high_q;
      2:       v = low_q + 1;
      3:       v = low_q - 1;
      4:       v = high_q + 1;
      5:       v = high_q - 1;
      6:       v = $urandom_range(1) ? 32'h0 : 32'hffff_ffff;
      default: v = $urandom;
    endcase
    return v & span[31:0];
  endfunction

  task automatic random_config();
    int unsigned                   choice;
    int unsigned                   vb;
    logic [63:0]                   span;
    logic [31:0]                   lo;
    logic [31:0]                   hi;
    logic [31:0]                   swap;
    logic [bpps_pkg::GROUPS_W-1:0] groups;
    choice = $urandom_range(19);
    if (choice == 0) vb = 0;
    else if (choice == 1) vb = $urandom_range(63, 33);
    else if (choice < 4) vb = 32;
    else if (choice < 7) vb = $urandom_range(31, 9);
    else vb = $urandom_range(8, 1);
    span = (64'd1 << ((vb == 0) ? 1 : (vb > MAX_PLANES) ? MAX_PLANES : vb)) - 1;
    lo = $urandom & span[31:0];
    hi = $urandom & span[31:0];
    case ($urandom_range(5))
      0: lo = 32'h0;
      1: hi = 32'hffff_ffff;
      2: hi = lo;
      default: ;
    endcase
    if ($urandom_range(3) != 0 && lo > hi) begin
      swap = lo;
      lo = hi;
      hi = swap;
    end
    case ($urandom_range(9))
      0:       groups = '0;
      1:       groups = '1;
      2:       groups = bpps_pkg::GROUP_MAX;
      default: groups = bpps_pkg::GROUPS_W'($urandom_range(6, 1));
    endcase
    set_config(bpps_pkg::MODE_W'($urandom_range(7)), vb, lo, hi, groups);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_groups.size() == 0) begin
        $error("unexpected result: row_mask %h match_total %0d scan_done %0b",
               out_tdata[31:0], out_tdata[32 +: bpps_pkg::COUNT_W], out_tlast);
        errors++;
      end else begin
        got_group = expected_groups.pop_front();
        if (out_tdata[31:0] !== got_group.row_mask) begin
          $error("row_mask: expected %h, got %h", got_group.row_mask, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[32 +: bpps_pkg::COUNT_W] !== got_group.match_total) begin
          $error("match_total: expected %0d, got %0d", got_group.match_total,
                 out_tdata[32 +: bpps_pkg::COUNT_W]);
          errors++;
        end
        if (out_tlast !== got_group.scan_done) begin
          $error("scan_done: expected %0b, got %0b", got_group.scan_done, out_tlast);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off counted here
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        out_tready <= 1'b0;
        hold_off_cycles--;
      end else begin
        out_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // defaults: exclusive between with both bounds zero never matches
  task automatic test_reset_state();
    send_plane(32'h0);
    send_plane(32'hffff_ffff);
    repeat (30) send_plane($urandom);
    drain();
  endtask

  task automatic test_predicates();
    row_set_t rows;
    for (int k = 0; k < ROWS; k++) rows[k] = k % 4;
    set_config(bpps_pkg::PRED_LT, 2, 32'd1, 32'd3, bpps_pkg::GROUPS_W'(8));
    @(posedge clk);
    for (int m = 0; m < 8; m++) begin
      write_reg(bpps_pkg::REG_PRED_MODE, bpps_pkg::CFG_DATA_W'(m));
      cfg_we <= 1'b0;
      send_rows(rows, 2);
      drain();
    end
    // empty between: low above high, then low equal to high
    set_config(bpps_pkg::PRED_BTW, 2, 32'd3, 32'd1, bpps_pkg::GROUPS_W'(1));
    send_rows(rows, 2);
    drain();
    set_config(bpps_pkg::PRED_BTW, 2, 32'd2, 32'd2, bpps_pkg::GROUPS_W'(1));
    send_rows(rows, 2);
    drain();
  endtask

  // zero planes act as one; zero groups act as one
  task automatic test_plane_count_limits();
    set_config(bpps_pkg::PRED_GT, 0, 32'h0, 32'hffff_ffff, bpps_pkg::GROUPS_W'(0));
    send_plane(32'hffff_ffff);
    drain();
    write_reg(bpps_pkg::REG_PRED_MODE, bpps_pkg::CFG_DATA_W'(bpps_pkg::PRED_EQ));
    cfg_we <= 1'b0;
    send_plane(32'h0);
    drain();
  endtask

  task automatic test_mid_group_lowering();
    set_config(bpps_pkg::PRED_LE, 4, 32'd5, 32'd0, bpps_pkg::GROUPS_W'(2));
    send_plane($urandom);
    send_plane($urandom);
    drain();
    write_reg(bpps_pkg::REG_VALUE_BITS, bpps_pkg::CFG_DATA_W'(1));
    cfg_we <= 1'b0;
    send_plane($urandom);
    drain();
  endtask

  // stall the output long enough for the block to close its input
  task automatic test_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    set_config(bpps_pkg::PRED_GE, 1, 32'h0, 32'h0, bpps_pkg::GROUPS_W'(5));
    hold_off_cycles = 200;
    repeat (60) send_plane($urandom);
    drain();
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                   input int unsigned plane_budget);
    row_set_t    rows;
    int unsigned vb;
    int unsigned start;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    start = planes_sent;
    while (planes_sent - start < plane_budget) begin
      random_config();
      vb = planes_per_group();
      repeat ($urandom_range(6, 1)) begin
        for (int k = 0; k < ROWS; k++) rows[k] = pick_row(vb);
        if ($urandom_range(9) == 0) begin
          repeat (vb) send_plane($urandom);
        end else begin
          // now and then cut a group short so the next write lands mid-group
          send_rows(rows, ($urandom_range(11) == 0) ? $urandom_range(vb) : vb);
        end
      end
      drain();
    end
  endtask

  initial begin
    errors = 0;
    hold_off_cycles = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    planes_sent = 0;
    mode_q = bpps_pkg::PRED_BTW;
    vbits_q = bpps_pkg::VBITS_W'(MAX_PLANES);
    low_q = '0;
    high_q = '0;
    groups_q = bpps_pkg::GROUPS_W'(1);
    clear_group_masks();
    group_no = 0;
    match_sum = 0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_addr <= '0;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_predicates();
    test_plane_count_limits();
    test_mid_group_lowering();
    test_backpressure();
    test_random_phase(0, 0, 360);
    test_random_phase(70, 0, 360);
    test_random_phase(0, 70, 360);
    test_random_phase(29, 29, 360);
    drain();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
